>>> src/ep2cal_pkg.sv
package ep2cal_pkg;

	// field widths
	localparam int SECS_W  = 38;
	localparam int FRAC_W  = 20;
	localparam int DAYS_W  = 22;
	localparam int YEAR_W  = 14;
	localparam int YMOD_W  = 9;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int USEC_W  = 20;
	localparam int PROD_W  = FRAC_W + USEC_W;
	localparam int CNT_W   = 5;
	localparam int PC_W    = 4;

	localparam int FRACTION_BITS_DEF = 20;

	// calendar constants
	localparam logic [SECS_W-1:0]  SECS_PER_DAY  = 38'd86400;
	localparam logic [SECS_W-1:0]  SECS_PER_HOUR = 38'd3600;
	localparam logic [SECS_W-1:0]  SECS_PER_MIN  = 38'd60;
	localparam logic [SECS_W-1:0]  DAYS_PER_400Y = 38'd146097;
	localparam logic [USEC_W-1:0]  USEC_PER_SEC  = 20'd1000000;
	localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 14'd1970;
	localparam logic [YMOD_W-1:0]  EPOCH_YMOD    = 9'd370;

	// step addresses
	localparam logic [PC_W-1:0] PC_DAYS   = 4'd0;
	localparam logic [PC_W-1:0] PC_Y400   = 4'd1;
	localparam logic [PC_W-1:0] PC_Y100   = 4'd2;
	localparam logic [PC_W-1:0] PC_Y4     = 4'd3;
	localparam logic [PC_W-1:0] PC_Y1     = 4'd4;
	localparam logic [PC_W-1:0] PC_MONTH  = 4'd5;
	localparam logic [PC_W-1:0] PC_HOURS  = 4'd6;
	localparam logic [PC_W-1:0] PC_MINS   = 4'd7;
	localparam logic [PC_W-1:0] PC_FINISH = 4'd8;

	// how a step repeats
	typedef enum logic [1:0] {
		M_SHIFT,
		M_LOOP,
		M_END
	} mode_t;

	// which constant the step compares against
	typedef enum logic [2:0] {
		K_DAY,
		K_HOUR,
		K_MIN,
		K_400Y,
		K_100Y,
		K_4Y,
		K_1Y,
		K_MON
	} ksel_t;

	typedef struct packed {
		mode_t            mode;
		ksel_t            ksel;
		logic [CNT_W-1:0] cnt0;
		logic [PC_W-1:0]  nxt;
	} ucode_t;

	// control store
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
		ucode_t w;
		case (addr)
			PC_DAYS:  w = '{mode: M_SHIFT, ksel: K_DAY,  cnt0: 5'd21, nxt: PC_Y400};
			PC_Y400:  w = '{mode: M_LOOP,  ksel: K_400Y, cnt0: 5'd0,  nxt: PC_Y100};
			PC_Y100:  w = '{mode: M_LOOP,  ksel: K_100Y, cnt0: 5'd0,  nxt: PC_Y4};
			PC_Y4:    w = '{mode: M_LOOP,  ksel: K_4Y,   cnt0: 5'd0,  nxt: PC_Y1};
			PC_Y1:    w = '{mode: M_LOOP,  ksel: K_1Y,   cnt0: 5'd0,  nxt: PC_MONTH};
			PC_MONTH: w = '{mode: M_LOOP,  ksel: K_MON,  cnt0: 5'd0,  nxt: PC_HOURS};
			PC_HOURS: w = '{mode: M_SHIFT, ksel: K_HOUR, cnt0: 5'd4,  nxt: PC_MINS};
			PC_MINS:  w = '{mode: M_SHIFT, ksel: K_MIN,  cnt0: 5'd5,  nxt: PC_FINISH};
			default:  w = '{mode: M_END,   ksel: K_DAY,  cnt0: 5'd0,  nxt: PC_DAYS};
		endcase
		return w;
	endfunction

	// leap year from year mod 400
	function automatic logic leap_mod400(input logic [YMOD_W-1:0] ymod);
		return (ymod[1:0] == 2'b00) && !(ymod inside {9'd100, 9'd200, 9'd300});
	endfunction

	// days in month, january is 1
	function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> src/epoch_seconds_to_calendar_unit.sv
// unix seconds plus binary fraction to gregorian date and time of day
// steps from input accept to result valid: 22 division steps for days, one step per
// 400/100/4/1-year block and per month plus one exit step per loop, 11 steps for
// hours and minutes, and one step to register the result
// a new timestamp is taken only once the last one is done; a result not taken holds the sequencer
// reset: sequencer idle, no result pending; no other state
module epoch_seconds_to_calendar_unit #(
	parameter int FRACTION_BITS = ep2cal_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ep2cal_pkg::SECS_W-1:0]   whole_seconds,
	input  logic [ep2cal_pkg::FRAC_W-1:0]   sub_second,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ep2cal_pkg::YEAR_W-1:0]   year,
	output logic [ep2cal_pkg::MONTH_W-1:0]  month,
	output logic [ep2cal_pkg::DAY_W-1:0]    day,
	output logic [ep2cal_pkg::HOUR_W-1:0]   hour,
	output logic [ep2cal_pkg::MIN_W-1:0]    minute,
	output logic [ep2cal_pkg::SEC_W-1:0]    second,
	output logic [ep2cal_pkg::USEC_W-1:0]   microseconds
);
	import ep2cal_pkg::*;

	localparam int MaskBits = (FRACTION_BITS < FRAC_W) ? FRACTION_BITS : FRAC_W;
	localparam logic [FRAC_W-1:0] FracMask = FRAC_W'((64'd1 << MaskBits) - 64'd1);
	localparam logic [PROD_W:0] RoundHalf = (PROD_W+1)'(64'd1 << (FRACTION_BITS - 1));

	// control state
	logic             busy_q;
	logic             out_valid_q;
	logic [PC_W-1:0]  pc_q;
	logic [CNT_W-1:0] cnt_q;

	// datapath registers
	logic [SECS_W-1:0]  rem_q;
	logic [DAYS_W-1:0]  days_q;
	logic [YEAR_W-1:0]  year_q;
	logic [YMOD_W-1:0]  ymod_q;
	logic [MONTH_W-1:0] month_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [MIN_W-1:0]   minute_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [PROD_W-1:0]  prod_q;

	// result registers
	logic [YEAR_W-1:0]  year_out_q;
	logic [MONTH_W-1:0] month_out_q;
	logic [DAY_W-1:0]   day_out_q;
	logic [HOUR_W-1:0]  hour_out_q;
	logic [MIN_W-1:0]   minute_out_q;
	logic [SEC_W-1:0]   second_out_q;
	logic [USEC_W-1:0]  usec_out_q;

	ucode_t            uw;
	ucode_t            uw_nxt;
	ucode_t            uw_first;
	logic              accept;
	logic              finish;
	logic              leap;
	logic [SECS_W-1:0] opa;
	logic [SECS_W-1:0] kval;
	logic [SECS_W-1:0] diff;
	logic              ge;
	logic              take;
	logic              step_done;
	logic [PROD_W:0]   usec_sum;

	assign uw       = ucode_rom(pc_q);
	assign uw_nxt   = ucode_rom(uw.nxt);
	assign uw_first = ucode_rom(PC_DAYS);
	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign finish   = busy_q && (uw.mode == M_END) && (!out_valid_q || out_ready);
	assign leap     = leap_mod400(ymod_q);

	// operand and constant for the current step
	always_comb begin
		opa  = {{(SECS_W-DAYS_W){1'b0}}, days_q};
		kval = SECS_PER_DAY;
		case (uw.ksel)
			K_DAY: begin
				opa  = rem_q;
				kval = SECS_PER_DAY << cnt_q;
			end
			K_HOUR: begin
				opa  = rem_q;
				kval = SECS_PER_HOUR << cnt_q;
			end
			K_MIN: begin
				opa  = rem_q;
				kval = SECS_PER_MIN << cnt_q;
			end
			K_400Y: kval = DAYS_PER_400Y;
			K_100Y: kval = (ymod_q == EPOCH_YMOD) ? 38'd36525 : 38'd36524;
			K_4Y:   kval = (ymod_q inside {9'd98, 9'd198, 9'd298}) ? 38'd1460 : 38'd1461;
			K_1Y:   kval = leap ? 38'd366 : 38'd365;
			K_MON:  kval = {{(SECS_W-5){1'b0}}, month_len(month_q, leap)};
			default: kval = SECS_PER_DAY;
		endcase
	end

	// compare and subtract
	assign ge   = opa >= kval;
	assign diff = opa - kval;

	// step condition
	always_comb begin
		take      = ge;
		step_done = 1'b0;
		case (uw.mode)
			M_SHIFT: step_done = (cnt_q == '0);
			M_LOOP: begin
				if (uw.ksel == K_MON) begin
					take = ge && (month_q < 4'd12);
				end
				step_done = !take;
			end
			default: begin
				take      = 1'b0;
				step_done = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= PC_DAYS;
			cnt_q       <= '0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= PC_DAYS;
				cnt_q  <= uw_first.cnt0;
			end else if (finish) begin
				busy_q <= 1'b0;
				pc_q   <= PC_DAYS;
			end else if (busy_q && uw.mode != M_END) begin
				if (step_done) begin
					pc_q  <= uw.nxt;
					cnt_q <= uw_nxt.cnt0;
				end else if (uw.mode == M_SHIFT) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= {{USEC_W{1'b0}}, frac_q} * {{FRAC_W{1'b0}}, USEC_PER_SEC};
		if (accept) begin
			rem_q   <= whole_seconds;
			frac_q  <= sub_second & FracMask;
			year_q  <= EPOCH_YEAR;
			ymod_q  <= EPOCH_YMOD;
			month_q <= 4'd1;
		end else if (busy_q && uw.mode != M_END) begin
			case (uw.ksel)
				K_DAY: begin
					days_q <= {days_q[DAYS_W-2:0], ge};
					if (ge) rem_q <= diff;
				end
				K_HOUR: begin
					hour_q <= {hour_q[HOUR_W-2:0], ge};
					if (ge) rem_q <= diff;
				end
				K_MIN: begin
					minute_q <= {minute_q[MIN_W-2:0], ge};
					if (ge) rem_q <= diff;
				end
				K_400Y: begin
					if (take) begin
						days_q <= diff[DAYS_W-1:0];
						year_q <= year_q + 14'd400;
					end
				end
				K_100Y: begin
					if (take) begin
						days_q <= diff[DAYS_W-1:0];
						year_q <= year_q + 14'd100;
						ymod_q <= (ymod_q >= 9'd300) ? ymod_q - 9'd300 : ymod_q + 9'd100;
					end
				end
				K_4Y: begin
					if (take) begin
						days_q <= diff[DAYS_W-1:0];
						year_q <= year_q + 14'd4;
						ymod_q <= (ymod_q >= 9'd396) ? ymod_q - 9'd396 : ymod_q + 9'd4;
					end
				end
				K_1Y: begin
					if (take) begin
						days_q <= diff[DAYS_W-1:0];
						year_q <= year_q + 14'd1;
						ymod_q <= (ymod_q == 9'd399) ? 9'd0 : ymod_q + 9'd1;
					end
				end
				K_MON: begin
					if (take) begin
						days_q  <= diff[DAYS_W-1:0];
						month_q <= month_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// fraction rounded half up to microseconds
	assign usec_sum = {1'b0, prod_q} + RoundHalf;

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			year_out_q   <= year_q;
			month_out_q  <= month_q;
			day_out_q    <= days_q[DAY_W-1:0] + 5'd1;
			hour_out_q   <= hour_q;
			minute_out_q <= minute_q;
			second_out_q <= rem_q[SEC_W-1:0];
			usec_out_q   <= USEC_W'(usec_sum >> FRACTION_BITS);
		end
	end

	assign out_valid    = out_valid_q;
	assign year         = year_out_q;
	assign month        = month_out_q;
	assign day          = day_out_q;
	assign hour         = hour_out_q;
	assign minute       = minute_out_q;
	assign second       = second_out_q;
	assign microseconds = usec_out_q;

endmodule

>>> verif/epoch_seconds_to_calendar_unit_test.sv
module epoch_seconds_to_calendar_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ep2cal_pkg::*;

	localparam int NUM_RANDOM = 900;
	localparam int NUM_ROWS   = 20;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 150;
	localparam longint unsigned SECS_MAX = (64'd1 << SECS_W) - 64'd1;
	localparam longint unsigned SECS_Y9999_END = 64'd253402300800;

	// one decoded calendar date
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
		logic [USEC_W-1:0]  usec;
	} cal_t;

	// one row of the directed timestamp table
	typedef struct packed {
		logic [SECS_W-1:0] secs;
		logic [FRAC_W-1:0] frac;
		logic              typed;
		cal_t              want;
	} stamp_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SECS_W-1:0] whole_seconds = '0;
	logic [FRAC_W-1:0] sub_second = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day;
	logic [HOUR_W-1:0]  hour;
	logic [MIN_W-1:0]   minute;
	logic [SEC_W-1:0]   second;
	logic [USEC_W-1:0]  microseconds;

	cal_t due_dates[$];
	int dates_checked = 0;
	int date_errors = 0;
	int past_9999 = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	epoch_seconds_to_calendar_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.whole_seconds(whole_seconds),
		.sub_second   (sub_second),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year         (year),
		.month        (month),
		.day          (day),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.microseconds (microseconds)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// gregorian 4/100/400 rule
	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// whole 400-year blocks, then whole years, then whole months, are peeled off the day count
	function automatic cal_t unix_to_date(input logic [SECS_W-1:0] secs,
			input logic [FRAC_W-1:0] frac);
		cal_t d;
		longint unsigned day_cnt, tod, fr, us, mlen;
		int unsigned yr, mo;
		fr = 64'(frac) & ((64'd1 << FRACTION_BITS_DEF) - 64'd1);
		us = (fr * 64'd1000000 + (64'd1 << (FRACTION_BITS_DEF - 1))) >> FRACTION_BITS_DEF;
		day_cnt = 64'(secs) / 64'd86400;
		tod = 64'(secs) % 64'd86400;
		yr = 1970 + 32'(day_cnt / 64'd146097) * 400;
		day_cnt = day_cnt % 64'd146097;
		while (day_cnt >= (is_leap(yr) ? 64'd366 : 64'd365)) begin
			day_cnt -= is_leap(yr) ? 64'd366 : 64'd365;
			yr++;
		end
		mo = 1;
		while (mo < 12) begin
			case (mo)
				2:         mlen = is_leap(yr) ? 64'd29 : 64'd28;
				4, 6, 9, 11: mlen = 64'd30;
				default:   mlen = 64'd31;
			endcase
			if (day_cnt < mlen)
				break;
			day_cnt -= mlen;
			mo++;
		end
		d.year = YEAR_W'(yr);
		d.month = MONTH_W'(mo);
		d.day = DAY_W'(day_cnt + 64'd1);
		d.hour = HOUR_W'(tod / 64'd3600);
		d.minute = MIN_W'((tod % 64'd3600) / 64'd60);
		d.second = SEC_W'(tod % 64'd60);
		d.usec = USEC_W'(us);
		return d;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	// present one timestamp and hold it until taken, then queue its date
	task automatic send_stamp(input logic [SECS_W-1:0] secs, input logic [FRAC_W-1:0] frac,
			input logic typed, input cal_t want);
		int gap;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		whole_seconds <= secs;
		sub_second <= frac;
		do
			@(posedge clk);
		while (!in_ready);
		due_dates.insert(due_dates.size(), typed ? want : unix_to_date(secs, frac));
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left <= gap_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each returned date with the oldest one queued
	always @(posedge clk) begin
		cal_t exp_date;
		if (arst_n && out_valid && out_ready) begin
			if (due_dates.size() == 0) begin
				$error("date returned with none outstanding");
				date_errors++;
			end else begin
				exp_date = due_dates.pop_front();
				dates_checked++;
				if (exp_date.year > YEAR_W'(9999))
					past_9999++;
				if (year !== exp_date.year) begin
					$error("year: expected %0d, got %0d", exp_date.year, year);
					date_errors++;
				end
				if (month !== exp_date.month) begin
					$error("month: expected %0d, got %0d", exp_date.month, month);
					date_errors++;
				end
				if (day !== exp_date.day) begin
					$error("day: expected %0d, got %0d", exp_date.day, day);
					date_errors++;
				end
				if (hour !== exp_date.hour) begin
					$error("hour: expected %0d, got %0d", exp_date.hour, hour);
					date_errors++;
				end
				if (minute !== exp_date.minute) begin
					$error("minute: expected %0d, got %0d", exp_date.minute, minute);
					date_errors++;
				end
				if (second !== exp_date.second) begin
					$error("second: expected %0d, got %0d", exp_date.second, second);
					date_errors++;
				end
				if (microseconds !== exp_date.usec) begin
					$error("microseconds: expected %0d, got %0d", exp_date.usec,
						microseconds);
					date_errors++;
				end
			end
		end
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		stamp_row_t rows [NUM_ROWS];
		longint unsigned dd, rem, secs64;
		logic [FRAC_W-1:0] frac;
		int unsigned yr;

		// epoch, fraction rounding, leap rules, 2038, end of year 9999, bit patterns
		rows = '{
			'{38'd0,            20'd0,       1'b1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0}},
			'{38'd0,            20'hFFFFF,   1'b1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd999999}},
			'{38'd0,            20'h80000,   1'b1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd500000}},
			'{38'd0,            20'd8192,    1'b1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd7813}},
			'{38'd0,            20'd1,       1'b1, '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd1}},
			'{38'd86399,        20'd0,       1'b1, '{14'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 20'd0}},
			'{38'd31535999,     20'd0,       1'b1, '{14'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 20'd0}},
			'{38'd31536000,     20'd0,       1'b1, '{14'd1971, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0}},
			'{38'd68169600,     20'd0,       1'b1, '{14'd1972, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 20'd0}},
			'{38'd951782400,    20'd0,       1'b1, '{14'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 20'd0}},
			'{38'd978220800,    20'd0,       1'b1, '{14'd2000, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 20'd0}},
			'{38'd1234567890,   20'd0,       1'b1, '{14'd2009, 4'd2, 5'd13, 5'd23, 6'd31, 6'd30, 20'd0}},
			'{38'd2147483647,   20'd0,       1'b1, '{14'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7, 20'd0}},
			'{38'd4107542399,   20'd0,       1'b1, '{14'd2100, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 20'd0}},
			'{38'd4107542400,   20'd0,       1'b1, '{14'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0}},
			'{38'd253402300799, 20'hFFFFF,   1'b1, '{14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 20'd999999}},
			'{38'd253402300800, 20'd0,       1'b1, '{14'd10000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0}},
			'{38'h3FFFFFFFFF,   20'h55555,   1'b0, '0},
			'{38'h2AAAAAAAAA,   20'hAAAAA,   1'b0, '0},
			'{38'h1555555555,   20'h55555,   1'b0, '0}
		};

		// reset once, inputs already at known values
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i])
			send_stamp(rows[i].secs, rows[i].frac, rows[i].typed, rows[i].want);

		// random timestamps: plain spread, full field range, and year/month edges
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					secs64 = {32'($urandom), 32'($urandom)} % SECS_Y9999_END;
				end
				4: begin
					secs64 = 64'({$urandom, $urandom}) & SECS_MAX;
				end
				default: begin
					yr = $urandom_range(1970, 10679);
					dd = 64'(365 * (yr - 1970)
						+ (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400 - 477);
					case ($urandom_range(0, 3))
						0: dd = (yr > 1970) ? dd - 64'd1 : dd;
						1: dd += 64'($urandom_range(57, 60));
						2: dd += 64'($urandom_range(0, 365));
						default: dd += 64'($urandom_range(364, 365));
					endcase
					case ($urandom_range(0, 2))
						0: rem = 64'd0;
						1: rem = 64'd86399;
						default: rem = 64'($urandom_range(0, 86399));
					endcase
					secs64 = dd * 64'd86400 + rem;
					if (secs64 > SECS_MAX)
						secs64 = SECS_MAX;
				end
			endcase
			case ($urandom_range(0, 5))
				0: frac = '0;
				1: frac = '1;
				2: frac = 20'h7FFFF + FRAC_W'($urandom_range(0, 2));
				default: frac = FRAC_W'($urandom);
			endcase
			send_stamp(SECS_W'(secs64), frac, 1'b0, '0);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// drain, then allow for any stray late result
		while (due_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d timestamps (%0d table rows, %0d random), %0d dates past year 9999",
			NUM_ROWS + NUM_RANDOM, NUM_ROWS, NUM_RANDOM, past_9999);
		$display("checked %0d dates field by field, %0d mismatches", dates_checked, date_errors);
		if (date_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
src/ep2cal_pkg.sv
src/epoch_seconds_to_calendar_unit.sv
verif/epoch_seconds_to_calendar_unit_test.sv
